FILE: hw/rtl/itp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_pkg: shared types and constants of the integer text parser
// Character codes, format codes, count width and the character class record.
// ----------------------------------------------------------------------------
package itp_pkg;

  // Field widths
  localparam int CharW   = 8;
  localparam int ValueW  = 64;
  localparam int OutCntW = 16;
  localparam int FmtW    = 2;

  // Internal consumed-character counter width (4..32)
  localparam int CountBits = 16;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // APB: one register, word addressed
  localparam int AddrW = 3;
  localparam int DataW = 32;
  localparam logic REG_NUMBER_FORMAT = 1'b0;

  // number_format codes; the fourth code acts as FMT_HEX
  localparam logic [FmtW-1:0] FMT_SIGNED_DEC   = 2'd0;
  localparam logic [FmtW-1:0] FMT_UNSIGNED_DEC = 2'd1;
  localparam logic [FmtW-1:0] FMT_HEX          = 2'd2;
  localparam logic [FmtW-1:0] FMT_RESET        = FMT_UNSIGNED_DEC;

  // ASCII codes
  localparam logic [CharW-1:0] CH_MINUS = 8'h2D;
  localparam logic [CharW-1:0] CH_ZERO  = 8'h30;
  localparam logic [CharW-1:0] CH_NINE  = 8'h39;
  localparam logic [CharW-1:0] CH_X     = 8'h78;
  localparam logic [CharW-1:0] CH_LA    = 8'h61;
  localparam logic [CharW-1:0] CH_LF    = 8'h66;
  localparam logic [CharW-1:0] CH_UA    = 8'h41;
  localparam logic [CharW-1:0] CH_UF    = 8'h46;

  // Classification of one character
  typedef struct packed {
    logic       is_dec;
    logic       is_hex;
    logic       is_minus;
    logic       is_x;
    logic       is_zero;
    logic [3:0] digit;
  } char_class_t;

endpackage

FILE: hw/rtl/itp_apb_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_apb_regs: configuration register file
// Holds number_format behind an APB slave; always ready, reads return value.
// ----------------------------------------------------------------------------
module itp_apb_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [itp_pkg::AddrW-1:0]   paddr,
  input  logic [itp_pkg::DataW-1:0]   pwdata,
  output logic [itp_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output logic [itp_pkg::FmtW-1:0]    number_format_o
);
  import itp_pkg::*;

  logic [FmtW-1:0] fmt_q, fmt_d;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_NUMBER_FORMAT);

  // register write
  always_comb begin
    fmt_d = fmt_q;
    if (wr_en) begin
      fmt_d = pwdata[FmtW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q <= FMT_RESET;
    end else begin
      fmt_q <= fmt_d;
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NUMBER_FORMAT) begin
      prdata = {{(DataW-FmtW){1'b0}}, fmt_q};
    end
  end

  assign number_format_o = fmt_q;

endmodule

FILE: hw/rtl/itp_char_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_char_decode: character classifier
// Flags decimal and hex digits, minus, lowercase x and zero; gives digit value.
// ----------------------------------------------------------------------------
module itp_char_decode (
  input  logic [itp_pkg::CharW-1:0] char_i,
  output itp_pkg::char_class_t      class_o
);
  import itp_pkg::*;

  logic dec, lower, upper;

  assign dec   = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign lower = (char_i >= CH_LA) && (char_i <= CH_LF);
  assign upper = (char_i >= CH_UA) && (char_i <= CH_UF);

  // letters a..f / A..F have low nibble 1..6, value is that plus nine
  always_comb begin
    class_o.is_dec   = dec;
    class_o.is_hex   = dec || lower || upper;
    class_o.is_minus = (char_i == CH_MINUS);
    class_o.is_x     = (char_i == CH_X);
    class_o.is_zero  = (char_i == CH_ZERO);
    class_o.digit    = dec ? char_i[3:0] : (char_i[3:0] + 4'd9);
  end

endmodule

FILE: hw/rtl/itp_parse_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itp_parse_core: input register, per-character parse step, result register
// The accumulator is kept already negated once a minus is seen, so the
// result register loads it directly.
// ----------------------------------------------------------------------------
module itp_parse_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [itp_pkg::FmtW-1:0]     number_format_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [itp_pkg::CharW-1:0]    in_char_i,
  input  logic                         in_end_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [itp_pkg::ValueW-1:0]   out_value_o,
  output logic [itp_pkg::OutCntW-1:0]  out_count_o
);
  import itp_pkg::*;

  // input register
  logic             in_valid_q, in_valid_d;
  logic [CharW-1:0] in_char_q;
  logic             in_end_q;
  logic             advance;

  // field state
  logic [ValueW-1:0]    acc_q, acc_d;
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic                 neg_q, neg_d;
  logic                 hex_q, hex_d;
  logic                 stop_q, stop_d;
  logic                 lz_q, lz_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  logic [ValueW-1:0]    out_value_q;
  logic [OutCntW-1:0]   out_count_q;

  char_class_t          cc;
  logic [FmtW-1:0]      fmt;
  logic                 first;
  logic                 take, take_dec, bump, halt;
  logic [ValueW-1:0]    acc_base, d_ext, acc_step, acc_n;
  logic [CountBits-1:0] cnt_n;
  logic                 neg_n, hex_n, lz_n;
  logic [31:0]          cnt_wide;
  logic [OutCntW-1:0]   cnt_sat;

  itp_char_decode u_decode (
    .char_i  (in_char_q),
    .class_o (cc)
  );

  // the held character moves on unless it ends a field and the result slot is stuck
  assign advance    = in_valid_q && (!in_end_q || !out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_char_q <= in_char_i;
      in_end_q  <= in_end_i;
    end
  end

  // parse decision for the held character
  always_comb begin
    fmt      = (number_format_i == FMT_SIGNED_DEC || number_format_i == FMT_UNSIGNED_DEC)
             ? number_format_i : FMT_HEX;
    first    = (cnt_q == '0);
    take     = 1'b0;
    take_dec = 1'b0;
    bump     = 1'b0;
    halt     = 1'b0;
    neg_n    = neg_q;
    hex_n    = hex_q;
    lz_n     = lz_q;
    if (!stop_q) begin
      if (fmt == FMT_SIGNED_DEC) begin
        if (first && cc.is_minus) begin
          neg_n = 1'b1;
          bump  = 1'b1;
        end else if (cc.is_dec) begin
          take     = 1'b1;
          take_dec = 1'b1;
          bump     = 1'b1;
        end else begin
          halt = 1'b1;
        end
      end else if (fmt == FMT_UNSIGNED_DEC && !hex_q) begin
        if (cc.is_dec) begin
          lz_n     = first && cc.is_zero;
          take     = 1'b1;
          take_dec = 1'b1;
          bump     = 1'b1;
        end else if (cc.is_x && lz_q && !in_end_q) begin
          hex_n = 1'b1;
          lz_n  = 1'b0;
          bump  = 1'b1;
        end else begin
          halt = 1'b1;
        end
      end else begin
        if (cc.is_x && lz_q) begin
          lz_n = 1'b0;
          bump = 1'b1;
        end else if (cc.is_hex) begin
          lz_n = first && cc.is_zero;
          take = 1'b1;
          bump = 1'b1;
        end else begin
          halt = 1'b1;
        end
      end
    end
    if (halt) begin
      lz_n = 1'b0;
    end
  end

  // accumulate: times ten by two shifts, or a nibble shift; digit subtracted when negative
  always_comb begin
    acc_base = take_dec ? ((acc_q << 3) + (acc_q << 1)) : (acc_q << 4);
    d_ext    = {{(ValueW-4){1'b0}}, cc.digit};
    if (neg_q) begin
      d_ext = ~d_ext + 1'b1;
    end
    acc_step = acc_base + d_ext;
    acc_n    = take ? acc_step : acc_q;
    cnt_n    = (bump && cnt_q != CountMax) ? cnt_q + 1'b1 : cnt_q;
  end

  // state update; field end clears it
  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    hex_d  = hex_q;
    stop_d = stop_q;
    lz_d   = lz_q;
    if (advance) begin
      if (in_end_q) begin
        acc_d  = '0;
        cnt_d  = '0;
        neg_d  = 1'b0;
        hex_d  = 1'b0;
        stop_d = 1'b0;
        lz_d   = 1'b0;
      end else begin
        acc_d  = acc_n;
        cnt_d  = cnt_n;
        neg_d  = neg_n;
        hex_d  = hex_n;
        stop_d = stop_q || halt;
        lz_d   = lz_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      hex_q  <= 1'b0;
      stop_q <= 1'b0;
      lz_q   <= 1'b0;
    end else begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      neg_q  <= neg_d;
      hex_q  <= hex_d;
      stop_q <= stop_d;
      lz_q   <= lz_d;
    end
  end

  // saturate count to the output width
  always_comb begin
    cnt_wide = 32'(cnt_n);
    cnt_sat  = (cnt_wide > 32'h0000_FFFF) ? 16'hFFFF : cnt_wide[OutCntW-1:0];
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q;
    if (advance && in_end_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_end_q) begin
      out_value_q <= acc_n;
      out_count_q <= cnt_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_count_o = out_count_q;

endmodule

FILE: hw/rtl/integer_text_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_text_parser: streaming ASCII integer parser
//
//   channel   | dir | beat content
//   s_axis    | in  | tdata[7:0] char_code, tlast field_end
//   m_axis    | out | tdata[63:0] parsed_value, tdata[79:64] chars_consumed
//   apb       | in  | 0x0 number_format[1:0] (reset 1)
//
// One character per cycle unless a final character waits for the result slot;
// a field's result passes the input register, then the result register.
// The loop that sets the rate is the accumulator update through acc_q.
// Reset (rst_ni low, asynchronous) clears the field state and both stages.
// While a result waits on m_axis, non-final characters still flow; a final
// character is held in the input register until the result slot frees.
// ----------------------------------------------------------------------------
module integer_text_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // character stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] char_code
  input  logic                       s_axis_tlast,   // field_end
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [79:0]                m_axis_tdata,   // [63:0] parsed_value, [79:64] chars_consumed
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [itp_pkg::AddrW-1:0]  paddr,
  input  logic [itp_pkg::DataW-1:0]  pwdata,
  output logic [itp_pkg::DataW-1:0]  prdata,
  output logic                       pready
);
  import itp_pkg::*;

  logic [FmtW-1:0]    number_format;
  logic [ValueW-1:0]  parsed_value;
  logic [OutCntW-1:0] chars_consumed;

  itp_apb_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .number_format_o (number_format)
  );

  itp_parse_core u_core (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .number_format_i (number_format),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .in_char_i       (s_axis_tdata),
    .in_end_i        (s_axis_tlast),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_value_o     (parsed_value),
    .out_count_o     (chars_consumed)
  );

  assign m_axis_tdata = {chars_consumed, parsed_value};

endmodule
